>>> design/slmt_pkg.sv
// ============================================================================
// slmt_pkg
// Types and fixed constants of the multichannel scaled slew limiter.
// ============================================================================
package slmt_pkg;

    // Field widths
    localparam int CHAN_W   = 4;
    localparam int RAW_W    = 10;
    localparam int VALUE_W  = 12;
    localparam int CFG_IDX_W = 2;

    // Channel numbers are compared at this width so that the largest
    // channel count the parameters allow still fits
    localparam int CHAN_CMP_W = 5;

    typedef logic [CHAN_W-1:0]     chan_t;
    typedef logic [RAW_W-1:0]      raw_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CHAN_CMP_W-1:0] chan_cmp_t;

    // Channel formats
    typedef enum logic [1:0] {
        FMT_LOW_VOLT  = 2'd0,
        FMT_HIGH_VOLT = 2'd1,
        FMT_HIGH_AMP  = 2'd2,
        FMT_LOW_AMP   = 2'd3
    } fmt_t;

    // Decoded channel: format and whether the channel exists
    typedef struct packed {
        logic in_range;
        fmt_t fmt;
    } chan_info_t;

    // Register indexes
    localparam cfg_idx_t CFG_LOW_VOLT_LIMIT  = 2'd0;
    localparam cfg_idx_t CFG_HIGH_VOLT_LIMIT = 2'd1;
    localparam cfg_idx_t CFG_HIGH_AMP_LIMIT  = 2'd2;
    localparam cfg_idx_t CFG_LOW_AMP_LIMIT   = 2'd3;

    // Register reset values
    localparam value_t LOW_VOLT_LIMIT_RST  = 12'd2;
    localparam value_t HIGH_VOLT_LIMIT_RST = 12'd500;
    localparam value_t HIGH_AMP_LIMIT_RST  = 12'd5;
    localparam value_t LOW_AMP_LIMIT_RST   = 12'd5;

    // Last-output reset values per format
    localparam value_t VOLT_LAST_RST     = 12'd0;
    localparam value_t HIGH_AMP_LAST_RST = 12'd15;
    localparam value_t LOW_AMP_LAST_RST  = 12'd1;

    // Low voltage: v * 43 / 64
    localparam int LV_MUL    = 43;
    localparam int LV_SHIFT  = 6;
    localparam int LV_PROD_W = 16;

    // High voltage: v * 17 / 8
    localparam int HV_MUL    = 17;
    localparam int HV_SHIFT  = 3;
    localparam int HV_PROD_W = 15;

    // High current: (v * 21) / 100 as v * (21 * 5243) >> 19, exact for v < 1024
    localparam int HA_RECIP  = 110103;
    localparam int HA_SHIFT  = 19;
    localparam int HA_PROD_W = 27;
    localparam value_t HA_OFFSET = 12'd15;

    // Low current: (v * 19) / 1000 as v * (19 * 16778) >> 24, exact for v < 1024
    localparam int LA_RECIP  = 318782;
    localparam int LA_SHIFT  = 24;
    localparam int LA_PROD_W = 29;
    localparam value_t LA_OFFSET = 12'd1;

endpackage

>>> design/slmt_scale.sv
// ============================================================================
// slmt_scale
// Channel decode and constant scaling of a raw sample to tenths.
// ============================================================================
module slmt_scale #(
    parameter int LOW_VOLT_CHANNELS  = 3,
    parameter int HIGH_VOLT_CHANNELS = 4
) (
    input  slmt_pkg::chan_t      chan,
    input  slmt_pkg::raw_t       raw_sample,
    output slmt_pkg::chan_info_t info,
    output slmt_pkg::value_t     scaled
);

    localparam int HIGH_AMP_CHANNEL = LOW_VOLT_CHANNELS + HIGH_VOLT_CHANNELS;
    localparam int CHANNEL_COUNT    = HIGH_AMP_CHANNEL + 2;

    slmt_pkg::chan_cmp_t                  chan_cmp;
    logic [slmt_pkg::LV_PROD_W-1:0]       lv_prod;
    logic [slmt_pkg::HV_PROD_W-1:0]       hv_prod;
    logic [slmt_pkg::HA_PROD_W-1:0]       ha_prod;
    logic [slmt_pkg::LA_PROD_W-1:0]       la_prod;

    // Decode the channel into its format
    assign chan_cmp = slmt_pkg::chan_cmp_t'(chan);

    always_comb
    begin
        info.in_range = (chan_cmp < slmt_pkg::chan_cmp_t'(CHANNEL_COUNT));
        if (chan_cmp < slmt_pkg::chan_cmp_t'(LOW_VOLT_CHANNELS))
            info.fmt = slmt_pkg::FMT_LOW_VOLT;
        else if (chan_cmp < slmt_pkg::chan_cmp_t'(HIGH_AMP_CHANNEL))
            info.fmt = slmt_pkg::FMT_HIGH_VOLT;
        else if (chan_cmp == slmt_pkg::chan_cmp_t'(HIGH_AMP_CHANNEL))
            info.fmt = slmt_pkg::FMT_HIGH_AMP;
        else
            info.fmt = slmt_pkg::FMT_LOW_AMP;
    end

    // Constant products, one per format
    assign lv_prod = slmt_pkg::LV_PROD_W'(raw_sample) *
                     slmt_pkg::LV_PROD_W'(slmt_pkg::LV_MUL);
    assign hv_prod = slmt_pkg::HV_PROD_W'(raw_sample) *
                     slmt_pkg::HV_PROD_W'(slmt_pkg::HV_MUL);
    assign ha_prod = slmt_pkg::HA_PROD_W'(raw_sample) *
                     slmt_pkg::HA_PROD_W'(slmt_pkg::HA_RECIP);
    assign la_prod = slmt_pkg::LA_PROD_W'(raw_sample) *
                     slmt_pkg::LA_PROD_W'(slmt_pkg::LA_RECIP);

    // Shift down, add offset, select by format
    always_comb
    begin
        unique case (info.fmt)
            slmt_pkg::FMT_LOW_VOLT:
                scaled = slmt_pkg::value_t'(lv_prod[slmt_pkg::LV_PROD_W-1:slmt_pkg::LV_SHIFT]);
            slmt_pkg::FMT_HIGH_VOLT:
                scaled = slmt_pkg::value_t'(hv_prod[slmt_pkg::HV_PROD_W-1:slmt_pkg::HV_SHIFT]);
            slmt_pkg::FMT_HIGH_AMP:
                scaled = slmt_pkg::value_t'(ha_prod[slmt_pkg::HA_PROD_W-1:slmt_pkg::HA_SHIFT])
                         + slmt_pkg::HA_OFFSET;
            slmt_pkg::FMT_LOW_AMP:
                scaled = slmt_pkg::value_t'(la_prod[slmt_pkg::LA_PROD_W-1:slmt_pkg::LA_SHIFT])
                         + slmt_pkg::LA_OFFSET;
            default:
                scaled = '0;
        endcase
    end

endmodule

>>> design/slmt_clamp.sv
// ============================================================================
// slmt_clamp
// Limit the step from the previous output to the target by a step limit.
// ============================================================================
module slmt_clamp (
    input  slmt_pkg::value_t target,
    input  slmt_pkg::value_t prev,
    input  slmt_pkg::value_t limit,
    output slmt_pkg::value_t result
);

    slmt_pkg::value_t fall;
    slmt_pkg::value_t rise;

    assign fall = prev - target;
    assign rise = target - prev;

    // Pass the target unless it lies more than the limit away
    always_comb
    begin
        if ((prev > target) && (fall > limit))
            result = prev - limit;
        else if ((target > prev) && (rise > limit))
            result = prev + limit;
        else
            result = target;
    end

endmodule

>>> design/slmt_state.sv
// ============================================================================
// slmt_state
// Per-channel last output, one register per channel.
// ============================================================================
module slmt_state #(
    parameter int LOW_VOLT_CHANNELS  = 3,
    parameter int HIGH_VOLT_CHANNELS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  slmt_pkg::chan_t  chan,
    input  logic             wr_en,
    input  slmt_pkg::value_t wr_data,
    output slmt_pkg::value_t prev
);

    localparam int HIGH_AMP_CHANNEL = LOW_VOLT_CHANNELS + HIGH_VOLT_CHANNELS;
    localparam int LOW_AMP_CHANNEL  = HIGH_AMP_CHANNEL + 1;
    localparam int CHANNEL_COUNT    = HIGH_AMP_CHANNEL + 2;

    slmt_pkg::value_t    last_reg [CHANNEL_COUNT];
    slmt_pkg::chan_cmp_t chan_cmp;

    assign chan_cmp = slmt_pkg::chan_cmp_t'(chan);

    // Select the addressed channel
    always_comb
    begin
        prev = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++)
        begin
            if (chan_cmp == slmt_pkg::chan_cmp_t'(i))
                prev = last_reg[i];
        end
    end

    // Store the new output of the addressed channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                if (i == HIGH_AMP_CHANNEL)
                    last_reg[i] <= slmt_pkg::HIGH_AMP_LAST_RST;
                else if (i == LOW_AMP_CHANNEL)
                    last_reg[i] <= slmt_pkg::LOW_AMP_LAST_RST;
                else
                    last_reg[i] <= slmt_pkg::VOLT_LAST_RST;
            end
        end
        else
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                if (wr_en && (chan_cmp == slmt_pkg::chan_cmp_t'(i)))
                    last_reg[i] <= wr_data;
            end
        end
    end

endmodule

>>> design/multichannel_scaled_slew_limiter_top.sv
// ============================================================================
// multichannel_scaled_slew_limiter_top
// Scales converter samples per channel format and slew-limits each channel.
// ============================================================================
//
//  Channel   Signals                          Width  Direction
//  --------  -------------------------------  -----  ---------
//  input     in_valid/in_ready, chan,          4+10   in
//            raw_sample
//  output    out_valid/out_ready, out_chan,    4+12   out
//            limited_value
//  config    cfg_valid/cfg_ready, cfg_index,   2+12   in
//            cfg_data
//
//  One request per cycle sustained while the output is not stalled; an accepted
//  request passes through the input register, then the result register.
//  Scaling and clamp are combinational between the input register and the
//  result register, and the last output is written as the result register
//  loads, so back-to-back requests on one channel see each other's outputs.
//  Reset clears the valid flags and loads the limits and last outputs.
//  A stalled output holds the input register; input is taken while the input
//  register is empty or moves on.
// ============================================================================
module multichannel_scaled_slew_limiter_top #(
    parameter int LOW_VOLT_CHANNELS  = 3,
    parameter int HIGH_VOLT_CHANNELS = 4
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  slmt_pkg::chan_t     chan,
    input  slmt_pkg::raw_t      raw_sample,

    output logic                out_valid,
    input  logic                out_ready,
    output slmt_pkg::chan_t     out_chan,
    output slmt_pkg::value_t    limited_value,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  slmt_pkg::cfg_idx_t  cfg_index,
    input  slmt_pkg::value_t    cfg_data
);

    // Input register
    logic                 s1_valid_reg;
    slmt_pkg::chan_t      s1_chan_reg;
    slmt_pkg::raw_t       s1_raw_reg;

    // Result register
    logic                 out_valid_reg;
    slmt_pkg::chan_t      out_chan_reg;
    slmt_pkg::value_t     out_value_reg;
    slmt_pkg::value_t     out_value_next;

    // Step limits
    slmt_pkg::value_t     lv_limit_reg;
    slmt_pkg::value_t     hv_limit_reg;
    slmt_pkg::value_t     ha_limit_reg;
    slmt_pkg::value_t     la_limit_reg;

    logic                 s1_adv;
    logic                 in_acc;
    slmt_pkg::chan_info_t info;
    slmt_pkg::value_t     scaled;
    slmt_pkg::value_t     prev;
    slmt_pkg::value_t     limit;
    slmt_pkg::value_t     result;
    logic                 state_wr;

    // Handshake
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Scale the held request
    slmt_scale #(
        .LOW_VOLT_CHANNELS  (LOW_VOLT_CHANNELS),
        .HIGH_VOLT_CHANNELS (HIGH_VOLT_CHANNELS)
    ) u_scale (
        .chan       (s1_chan_reg),
        .raw_sample (s1_raw_reg),
        .info       (info),
        .scaled     (scaled)
    );

    // Pick the step limit of the format
    always_comb
    begin
        unique case (info.fmt)
            slmt_pkg::FMT_LOW_VOLT:  limit = lv_limit_reg;
            slmt_pkg::FMT_HIGH_VOLT: limit = hv_limit_reg;
            slmt_pkg::FMT_HIGH_AMP:  limit = ha_limit_reg;
            slmt_pkg::FMT_LOW_AMP:   limit = la_limit_reg;
            default:                 limit = '0;
        endcase
    end

    // Last output per channel
    assign state_wr = s1_adv && info.in_range;

    slmt_state #(
        .LOW_VOLT_CHANNELS  (LOW_VOLT_CHANNELS),
        .HIGH_VOLT_CHANNELS (HIGH_VOLT_CHANNELS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .chan    (s1_chan_reg),
        .wr_en   (state_wr),
        .wr_data (result),
        .prev    (prev)
    );

    // Clamp against the last output
    slmt_clamp u_clamp (
        .target (scaled),
        .prev   (prev),
        .limit  (limit),
        .result (result)
    );

    // Drop to zero for a channel that does not exist
    assign out_value_next = info.in_range ? result : '0;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_chan_reg <= chan;
            s1_raw_reg  <= raw_sample;
        end
        if (s1_adv)
        begin
            out_chan_reg  <= s1_chan_reg;
            out_value_reg <= out_value_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_limit_reg <= slmt_pkg::LOW_VOLT_LIMIT_RST;
            hv_limit_reg <= slmt_pkg::HIGH_VOLT_LIMIT_RST;
            ha_limit_reg <= slmt_pkg::HIGH_AMP_LIMIT_RST;
            la_limit_reg <= slmt_pkg::LOW_AMP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slmt_pkg::CFG_LOW_VOLT_LIMIT:  lv_limit_reg <= cfg_data;
                slmt_pkg::CFG_HIGH_VOLT_LIMIT: hv_limit_reg <= cfg_data;
                slmt_pkg::CFG_HIGH_AMP_LIMIT:  ha_limit_reg <= cfg_data;
                slmt_pkg::CFG_LOW_AMP_LIMIT:   la_limit_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_chan      = out_chan_reg;
    assign limited_value = out_value_reg;

    // A moving request always lands in the result register
    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result register not filled after advance");

    // A stalled result holds the input register
    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !s1_adv)
        else $error("input register advanced into a stalled result");

    // The clamped result moves at most the limit, or reaches the target
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && info.in_range) |->
            ((result == scaled) ||
             ((result >= prev) && ((result - prev) == limit)) ||
             ((result < prev) && ((prev - result) == limit))))
        else $error("clamped step exceeds the limit");

    // No state update for a channel that does not exist
    a_no_oob_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_wr |-> info.in_range)
        else $error("state written for an absent channel");

endmodule

>>> dv/tb_multichannel_scaled_slew_limiter_top.sv
// ============================================================================
// tb_multichannel_scaled_slew_limiter_top
// Self-checking bench for the per-channel scaling and slew limiting. It
// tracks the last output of every channel and the four step limits, predicts
// each limited value when a request is accepted, and compares every result in
// order. A directed pass over all channels and the field extremes comes
// first. Random phases follow, one per limit setting, with random idling on
// both channels in all phases but the last.
// ============================================================================
module tb_multichannel_scaled_slew_limiter_top;

    localparam int LV_CHANS         = 3;
    localparam int HV_CHANS         = 4;
    localparam int HIGH_AMP_CH      = LV_CHANS + HV_CHANS;
    localparam int LOW_AMP_CH       = HIGH_AMP_CH + 1;
    localparam int CHAN_COUNT       = LOW_AMP_CH + 1;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct {
        slmt_pkg::chan_t chan;
        slmt_pkg::raw_t  raw;
    } sample_req_t;

    typedef struct {
        slmt_pkg::chan_t  chan;
        slmt_pkg::value_t value;
    } limited_res_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               in_valid      = 1'b0;
    logic               in_ready;
    slmt_pkg::chan_t    chan          = '0;
    slmt_pkg::raw_t     raw_sample    = '0;
    logic               out_valid;
    logic               out_ready     = 1'b0;
    slmt_pkg::chan_t    out_chan;
    slmt_pkg::value_t   limited_value;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    slmt_pkg::cfg_idx_t cfg_index     = '0;
    slmt_pkg::value_t   cfg_data      = '0;

    // Shadow copy of the block's limits and per-channel history
    slmt_pkg::value_t step_limit [4];
    slmt_pkg::value_t last_value [CHAN_COUNT];

    sample_req_t  pending_reqs [$];
    limited_res_t expected_results [$];
    sample_req_t  next_req;
    limited_res_t want;
    int           raw_walk [16];
    int           send_gap      = 0;
    int           stall_left    = 0;
    int           mismatch_count = 0;
    int           cycle_count   = 0;
    bit           idle_en       = 1'b1;

    multichannel_scaled_slew_limiter_top #(
        .LOW_VOLT_CHANNELS  (LV_CHANS),
        .HIGH_VOLT_CHANNELS (HV_CHANS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .chan          (chan),
        .raw_sample    (raw_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_chan      (out_chan),
        .limited_value (limited_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Scale one sample by its channel format, clamp the step, update history
    function automatic limited_res_t scale_and_limit(input slmt_pkg::chan_t ch,
                                                     input slmt_pkg::raw_t raw);
        limited_res_t res;
        int unsigned  v;
        int unsigned  target;
        int unsigned  prev;
        int unsigned  lim;
        v         = raw;
        res.chan  = ch;
        res.value = '0;
        if (ch < CHAN_COUNT)
        begin
            if (ch < LV_CHANS)
            begin
                target = (v * 43) / 64;
                lim    = step_limit[slmt_pkg::FMT_LOW_VOLT];
            end
            else if (ch < HIGH_AMP_CH)
            begin
                target = (v * 17) / 8;
                lim    = step_limit[slmt_pkg::FMT_HIGH_VOLT];
            end
            else if (ch == HIGH_AMP_CH)
            begin
                target = (v * 21) / 100 + 15;
                lim    = step_limit[slmt_pkg::FMT_HIGH_AMP];
            end
            else
            begin
                target = (v * 19) / 1000 + 1;
                lim    = step_limit[slmt_pkg::FMT_LOW_AMP];
            end
            prev = last_value[ch];
            if (prev > target && prev - target > lim)
                target = prev - lim;
            else if (target > prev && target - prev > lim)
                target = prev + lim;
            res.value      = slmt_pkg::value_t'(target);
            last_value[ch] = res.value;
        end
        return res;
    endfunction

    // Draw a request: mostly valid channels, samples from extremes, uniform
    // values or a slow per-channel walk that lands near the step limits
    function automatic sample_req_t random_request();
        sample_req_t req;
        int          pick;
        int          ch;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            req.chan = slmt_pkg::chan_t'($urandom_range(CHAN_COUNT, 15));
        else
            req.chan = slmt_pkg::chan_t'($urandom_range(0, CHAN_COUNT - 1));
        ch   = req.chan;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            req.raw = ($urandom_range(0, 1) != 0) ? '1 : '0;
        else if (pick < 55)
            req.raw = slmt_pkg::raw_t'($urandom_range(0, 1023));
        else
        begin
            raw_walk[ch] = raw_walk[ch] + int'($urandom_range(0, 24)) - 12;
            if (raw_walk[ch] < 0)
                raw_walk[ch] = 0;
            if (raw_walk[ch] > 1023)
                raw_walk[ch] = 1023;
            req.raw = slmt_pkg::raw_t'(raw_walk[ch]);
        end
        return req;
    endfunction

    // Write one limit register; valid stays high for a following write
    task automatic write_limit(input slmt_pkg::cfg_idx_t idx, input slmt_pkg::value_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            slmt_pkg::CFG_LOW_VOLT_LIMIT:  step_limit[slmt_pkg::FMT_LOW_VOLT]  = data;
            slmt_pkg::CFG_HIGH_VOLT_LIMIT: step_limit[slmt_pkg::FMT_HIGH_VOLT] = data;
            slmt_pkg::CFG_HIGH_AMP_LIMIT:  step_limit[slmt_pkg::FMT_HIGH_AMP]  = data;
            default:                       step_limit[slmt_pkg::FMT_LOW_AMP]   = data;
        endcase
    endtask

    // Hold until every request is sent and every result has come back
    task automatic wait_idle();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // One limit setting, then random requests in two halves with a drain
    // between them
    task automatic run_phase(input slmt_pkg::value_t lv_lim, input slmt_pkg::value_t hv_lim,
                             input slmt_pkg::value_t ha_lim, input slmt_pkg::value_t la_lim,
                             input bit allow_idle);
        wait_idle();
        @(posedge clk);
        write_limit(slmt_pkg::CFG_LOW_VOLT_LIMIT, lv_lim);
        write_limit(slmt_pkg::CFG_HIGH_VOLT_LIMIT, hv_lim);
        write_limit(slmt_pkg::CFG_HIGH_AMP_LIMIT, ha_lim);
        write_limit(slmt_pkg::CFG_LOW_AMP_LIMIT, la_lim);
        cfg_valid <= 1'b0;
        for (int half = 0; half < 2; half++)
        begin
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            repeat (RANDOM_PER_PHASE / 2) pending_reqs.push_back(random_request());
            wait_idle();
        end
    endtask

    // Sequence: reset, directed pass, random phases, drain and verdict
    initial
    begin
        sample_req_t req;
        step_limit[slmt_pkg::FMT_LOW_VOLT]  = slmt_pkg::LOW_VOLT_LIMIT_RST;
        step_limit[slmt_pkg::FMT_HIGH_VOLT] = slmt_pkg::HIGH_VOLT_LIMIT_RST;
        step_limit[slmt_pkg::FMT_HIGH_AMP]  = slmt_pkg::HIGH_AMP_LIMIT_RST;
        step_limit[slmt_pkg::FMT_LOW_AMP]   = slmt_pkg::LOW_AMP_LIMIT_RST;
        for (int i = 0; i < CHAN_COUNT; i++)
            last_value[i] = slmt_pkg::VOLT_LAST_RST;
        last_value[HIGH_AMP_CH] = slmt_pkg::HIGH_AMP_LAST_RST;
        last_value[LOW_AMP_CH]  = slmt_pkg::LOW_AMP_LAST_RST;
        for (int i = 0; i < 16; i++)
            raw_walk[i] = 512;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every channel at full scale and back to zero
        for (int i = 0; i < CHAN_COUNT; i++)
        begin
            req.chan = slmt_pkg::chan_t'(i);
            req.raw  = '1;
            pending_reqs.push_back(req);
            req.raw  = '0;
            pending_reqs.push_back(req);
        end
        // Out-of-range channels give zero and leave history alone
        req.chan = slmt_pkg::chan_t'(CHAN_COUNT);
        req.raw  = '1;
        pending_reqs.push_back(req);
        req.chan = '1;
        req.raw  = '0;
        pending_reqs.push_back(req);
        req.raw  = '1;
        pending_reqs.push_back(req);
        req.chan = slmt_pkg::chan_t'(LOW_AMP_CH);
        pending_reqs.push_back(req);

        run_phase('0, '0, '0, '0, 1'b1);
        run_phase('1, '1, '1, '1, 1'b1);
        run_phase(slmt_pkg::value_t'($urandom_range(0, 15)),
                  slmt_pkg::value_t'($urandom_range(0, 15)),
                  slmt_pkg::value_t'($urandom_range(0, 15)),
                  slmt_pkg::value_t'($urandom_range(0, 15)), 1'b1);
        run_phase(slmt_pkg::value_t'($urandom_range(0, 4095)),
                  slmt_pkg::value_t'($urandom_range(0, 4095)),
                  slmt_pkg::value_t'($urandom_range(0, 4095)),
                  slmt_pkg::value_t'($urandom_range(0, 4095)), 1'b1);
        run_phase(slmt_pkg::value_t'(1), '1, '0,
                  slmt_pkg::value_t'($urandom_range(1, 8)), 1'b1);
        run_phase(slmt_pkg::LOW_VOLT_LIMIT_RST, slmt_pkg::HIGH_VOLT_LIMIT_RST,
                  slmt_pkg::HIGH_AMP_LIMIT_RST, slmt_pkg::LOW_AMP_LIMIT_RST, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Driver: predict on acceptance, then present the next request or idle
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(scale_and_limit(chan, raw_sample));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0 && idle_en && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid   <= 1'b1;
                    chan       <= next_req.chan;
                    raw_sample <= next_req.raw;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result: chan %0d value %0d",
                                 out_chan, limited_value);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_chan !== want.chan || limited_value !== want.value)
                    begin
                        if (mismatch_count < MAX_REPORTS)
                            $display("mismatch: chan exp %0d got %0d, value exp %0d got %0d",
                                     want.chan, out_chan, want.value, limited_value);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

>>> sim.f
design/slmt_pkg.sv
design/slmt_scale.sv
design/slmt_clamp.sv
design/slmt_state.sv
design/multichannel_scaled_slew_limiter_top.sv
dv/tb_multichannel_scaled_slew_limiter_top.sv
